// ===== hdl/rwsma_pkg.sv =====
// shared types, constants and helpers of the random walk sensor unit
// used by rwsma_prng, rwsma_cell and random_walk_sensor_moving_average_unit
package rwsma_pkg;

    localparam int LEVEL_W      = 16;
    localparam int WINDOW_DEPTH = 8;    // history depth, a power of two
    localparam int WIN_LOG2     = $clog2(WINDOW_DEPTH);
    localparam int WIN_CNT_W    = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;
    localparam int TOTAL_W      = LEVEL_W + WIN_LOG2;
    localparam int SUM_W        = LEVEL_W + 2;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 16'd500;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN_RST = 16'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST = 16'd1000;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET   =
        TOTAL_W'(LEVEL_RESET) << WIN_LOG2;

    localparam int PRNG_W = 31;
    localparam logic [PRNG_W-1:0] LCG_MUL    = 31'd1103515245;
    localparam logic [PRNG_W-1:0] LCG_ADD    = 31'd12345;
    localparam logic [PRNG_W-1:0] PRNG_SEED  = 31'd123456789;
    localparam logic [SUM_W-1:0]  STEP_BIAS  = 18'd5;
    localparam int                FOLD_W     = 12;    // sum of three 10-bit segments and a bit

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_TICK = 2'd1,
        OP_SET  = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        REG_LEVEL_MIN = 1'b0,
        REG_LEVEL_MAX = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RAND  = 5'b00010,
        ST_STORE = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
    } prng_ctl_t;

    typedef struct packed {
        logic       done;
        logic [3:0] step;   // state mod 11
    } prng_stat_t;

    // remainder by 11 of an 11-bit value: reciprocal estimate plus one fixup
    function automatic logic [3:0] mod11(input logic [10:0] v);
        logic [19:0] p;
        logic [7:0]  q;
        logic [10:0] r;
        p = 20'(v) * 20'd372;
        q = p[19:12];
        r = v - 11'(11'(q) * 11'd11);
        if (r >= 11'd11)
        begin
            r = r - 11'd11;
        end
        return r[3:0];
    endfunction

endpackage

// ===== hdl/random_walk_sensor_moving_average_unit.sv =====
// channel  dir  handshake            payload
// s        in   s_tvalid/s_tready    s_tuser[1:0] op, s_tdata[15:0] new_level
// m        out  m_tvalid/m_tready    m_tdata[15:0] current_level, [31:16] predicted_level
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// one word at a time: tick waits for the two-stage mod 11 and init shifts
// the midpoint through every history cell.
// after reset the history holds 500 everywhere, no clearing pass.
// a stalled result sits in the output register while the next word is taken.
//
// top level of the random walk level sensor with moving average
// depends on rwsma_pkg, rwsma_prng, rwsma_cell
module random_walk_sensor_moving_average_unit
    import rwsma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // new_level
    input  logic [1:0]  s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // current_level, predicted_level
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t               state_reg;
    op_t                  op_reg;
    logic [LEVEL_W-1:0]   nv_reg;
    logic [LEVEL_W-1:0]   level_min_reg, level_max_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [WIN_CNT_W-1:0] fill_cnt_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;

    logic                 accept;
    logic                 out_free;
    logic [LEVEL_W:0]     mid_sum;
    logic [SUM_W-1:0]     cand;
    logic [SUM_W-1:0]     floored;
    logic [LEVEL_W-1:0]   sat_level;
    logic                 shift;
    logic [LEVEL_W-1:0]   shift_in;
    logic [LEVEL_W-1:0]   cell_q [WINDOW_DEPTH];
    prng_ctl_t            prng_ctl;
    prng_stat_t           prng_stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign mid_sum   = {1'b0, level_min_reg} + {1'b0, level_max_reg};

    assign prng_ctl.start = accept && (op_t'(s_tuser) == OP_TICK);

    rwsma_prng u_prng
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (prng_ctl),
        .stat  (prng_stat)
    );

    // candidate as a signed sum, floor first then ceiling
    always_comb
    begin
        if (op_reg == OP_TICK)
        begin
            cand = SUM_W'(level_reg) + SUM_W'(prng_stat.step) - STEP_BIAS;
        end
        else
        begin
            cand = SUM_W'(nv_reg);
        end
        if ($signed(cand) < $signed(SUM_W'(level_min_reg)))
        begin
            floored = SUM_W'(level_min_reg);
        end
        else
        begin
            floored = cand;
        end
        if ($signed(floored) > $signed(SUM_W'(level_max_reg)))
        begin
            sat_level = level_max_reg;
        end
        else
        begin
            sat_level = floored[LEVEL_W-1:0];
        end
    end

    assign shift    = (state_reg == ST_STORE) || (state_reg == ST_FILL);
    assign shift_in = (state_reg == ST_STORE) ? sat_level : level_reg;

    // head cell holds the oldest entry, new words enter at the tail
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic [LEVEL_W-1:0] d;
        if (i == WINDOW_DEPTH - 1)
        begin : g_tail
            assign d = shift_in;
        end
        else
        begin : g_body
            assign d = cell_q[i+1];
        end
        rwsma_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (d),
            .q     (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_min_reg <= LEVEL_MIN_RST;
            level_max_reg <= LEVEL_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LEVEL_MIN: level_min_reg <= cfg_data;
                REG_LEVEL_MAX: level_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_INIT;
            level_reg    <= LEVEL_RESET;
            total_reg    <= TOTAL_RESET;
            fill_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= op_t'(s_tuser);
                        case (op_t'(s_tuser))
                            OP_INIT:
                            begin
                                level_reg    <= mid_sum[LEVEL_W:1];
                                total_reg    <= '0;
                                fill_cnt_reg <= '0;
                                state_reg    <= ST_FILL;
                            end
                            OP_TICK: state_reg <= ST_RAND;
                            OP_SET:  state_reg <= ST_STORE;
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_RAND:
                begin
                    if (prng_stat.done)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    level_reg <= sat_level;
                    total_reg <= total_reg - TOTAL_W'(cell_q[0]) + TOTAL_W'(sat_level);
                    state_reg <= ST_DONE;
                end
                ST_FILL:
                begin
                    total_reg    <= total_reg + TOTAL_W'(level_reg);
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                    if (fill_cnt_reg == WIN_CNT_W'(WINDOW_DEPTH - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nv_reg <= s_tdata;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {total_reg[TOTAL_W-1:WIN_LOG2], level_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/rwsma_prng.sv =====
// linear congruential generator with a two-stage remainder by 11
// depends on rwsma_pkg
module rwsma_prng
    import rwsma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  prng_ctl_t  ctl,
    output prng_stat_t stat
);

    logic [PRNG_W-1:0] prng_reg, prng_next;
    logic [FOLD_W-1:0] fold_reg;
    logic [FOLD_W-1:0] fold_sum;
    logic [10:0]       fold_low;
    logic [3:0]        rem_reg;
    logic [1:0]        stage_reg;
    logic              done_reg;

    // low 31 bits of the product are all the mask keeps
    assign prng_next = PRNG_W'(prng_reg * LCG_MUL + LCG_ADD);

    // 2**10 is 1 mod 11, so 10-bit segments can simply be added
    assign fold_sum = FOLD_W'(prng_reg[9:0]) + FOLD_W'(prng_reg[19:10])
                    + FOLD_W'(prng_reg[29:20]) + FOLD_W'(prng_reg[30]);
    assign fold_low = 11'(fold_reg[9:0]) + 11'(fold_reg[11:10]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prng_reg  <= PRNG_SEED;
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[0], ctl.start};
            done_reg  <= stage_reg[1];
            if (ctl.start)
            begin
                prng_reg <= prng_next;
            end
        end
    end

    // remainder datapath, registered in fold_reg and then rem_reg after the state steps
    always_ff @(posedge clk)
    begin
        fold_reg <= fold_sum;
        rem_reg  <= mod11(fold_low);
    end

    assign stat.done = done_reg;
    assign stat.step = rem_reg;

endmodule

// ===== hdl/rwsma_cell.sv =====
// one entry of the history chain, shifts toward the head on enable
// depends on rwsma_pkg
module rwsma_cell
    import rwsma_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic [LEVEL_W-1:0] d,
    output logic [LEVEL_W-1:0] q
);

    logic [LEVEL_W-1:0] entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= LEVEL_RESET;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule
